// ----- hdl/servo_status_reply_parser_defines.svh -----
// Assertion macros shared by the servo status reply parser checkers.
`ifndef SERVO_STATUS_REPLY_PARSER_DEFINES_SVH
`define SERVO_STATUS_REPLY_PARSER_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define SSRP_ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SSRP_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ssrp_pkg.sv -----
// Shared types, codes and helper functions of the servo status reply parser.
`timescale 1ns / 1ps

package ssrp_pkg;

    localparam int REPLY_MAX_BYTES_DEF = 20;
    // Longest reply minus its checksum byte.
    localparam int WINDOW_BYTES = 19;
    localparam int IDX_W = 5;
    localparam int ITEM_COUNT = 8;
    localparam int CMD_ERROR_BIT = 0;

    // Outcome codes
    localparam logic [1:0] OUTCOME_OK      = 2'd0;
    localparam logic [1:0] OUTCOME_BAD_SUM = 2'd1;
    localparam logic [1:0] OUTCOME_CMD_ERR = 2'd2;
    localparam logic [1:0] OUTCOME_SHORT   = 2'd3;

    // Register word index
    localparam logic REG_STATUS_ITEMS = 1'b0;

    // Item numbers in mask bit order
    localparam logic [2:0] ITEM_POS    = 3'd0;
    localparam logic [2:0] ITEM_AD     = 3'd1;
    localparam logic [2:0] ITEM_VEL    = 3'd2;
    localparam logic [2:0] ITEM_AUX    = 3'd3;
    localparam logic [2:0] ITEM_HOME   = 3'd4;
    localparam logic [2:0] ITEM_ID     = 3'd5;
    localparam logic [2:0] ITEM_PERROR = 3'd6;
    localparam logic [2:0] ITEM_POINTS = 3'd7;

    typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

    // Per-request event from the frame tracker
    typedef struct packed {
        logic done;
        logic timeout;
        logic sum_ok;
    } frame_ev_t;

    typedef struct packed {
        logic [7:0]  points;
        logic [15:0] perror;
        logic [7:0]  version;
        logic [7:0]  mtype;
        logic [31:0] home;
        logic [7:0]  aux;
        logic [15:0] velocity;
        logic [7:0]  adc;
        logic [31:0] position;
        logic [7:0]  status;
    } held_t;

    // Byte count of one reply item
    function automatic logic [2:0] item_size(input logic [2:0] item);
        logic [2:0] s;
        unique case (item)
            ITEM_POS:    s = 3'd4;
            ITEM_AD:     s = 3'd1;
            ITEM_VEL:    s = 3'd2;
            ITEM_AUX:    s = 3'd1;
            ITEM_HOME:   s = 3'd4;
            ITEM_ID:     s = 3'd2;
            ITEM_PERROR: s = 3'd2;
            ITEM_POINTS: s = 3'd1;
            default:     s = 3'd0;
        endcase
        return s;
    endfunction

    // Total reply length including status and checksum bytes
    function automatic logic [IDX_W-1:0] reply_length(input logic [7:0] mask);
        logic [IDX_W-1:0] n;
        n = IDX_W'(2);
        for (int b = 0; b < ITEM_COUNT; b++)
        begin
            if (mask[b])
                n = n + IDX_W'(item_size(3'(b)));
        end
        return n;
    endfunction

    // Byte position of an item inside the reply
    function automatic logic [IDX_W-1:0] item_offset(input logic [7:0] mask,
                                                     input logic [2:0] item);
        logic [IDX_W-1:0] n;
        n = IDX_W'(1);
        for (int b = 0; b < ITEM_COUNT; b++)
        begin
            if (mask[b] && (3'(b) < item))
                n = n + IDX_W'(item_size(3'(b)));
        end
        return n;
    endfunction

endpackage

// ----- hdl/ssrp_frame.sv -----
// Reply framing: byte counter, running checksum and reply byte store.
`timescale 1ns / 1ps

module ssrp_frame #(
    parameter int DEPTH = ssrp_pkg::REPLY_MAX_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic                timeout,
    input  logic [7:0]          status_items,
    output logic                ends_reply,
    output ssrp_pkg::frame_ev_t ev,
    output ssrp_pkg::window_t   window
);

    logic [ssrp_pkg::IDX_W-1:0] byte_index_reg;
    logic [ssrp_pkg::IDX_W-1:0] byte_index_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic [7:0]                 store_reg [DEPTH];
    logic [ssrp_pkg::IDX_W-1:0] last_index;
    logic                       at_last;
    logic                       take_byte;

    // Locate the checksum byte from the current mask
    assign last_index = ssrp_pkg::reply_length(status_items) - ssrp_pkg::IDX_W'(1);
    assign at_last    = (byte_index_reg >= last_index);
    assign take_byte  = step && !timeout && !at_last;

    // Flag a held request that would finish or abandon the reply
    assign ends_reply = timeout || at_last;

    assign ev.done    = step && (timeout || at_last);
    assign ev.timeout = timeout;
    assign ev.sum_ok  = (sum_reg == rx_byte);

    // Advance or restart the frame
    always_comb
    begin
        byte_index_next = byte_index_reg;
        sum_next        = sum_reg;
        if (take_byte)
        begin
            byte_index_next = byte_index_reg + ssrp_pkg::IDX_W'(1);
            sum_next        = sum_reg + rx_byte;
        end
        else if (ev.done)
        begin
            byte_index_next = '0;
            sum_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            sum_reg        <= sum_next;
        end
    end

    // Store each body byte at its own slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (take_byte && (byte_index_reg == ssrp_pkg::IDX_W'(i)))
                store_reg[i] <= rx_byte;
        end
    end

    // Expose the bytes the parser can reach
    always_comb
    begin
        for (int w = 0; w < ssrp_pkg::WINDOW_BYTES; w++)
            window[w] = store_reg[w];
    end

endmodule

// ----- hdl/ssrp_fields.sv -----
// Held status values, updated from the stored reply on a good checksum.
`timescale 1ns / 1ps

module ssrp_fields (
    input  logic                clk,
    input  logic                rst_n,
    input  ssrp_pkg::frame_ev_t ev,
    input  ssrp_pkg::window_t   window,
    input  logic [7:0]          status_items,
    output ssrp_pkg::held_t     held
);

    ssrp_pkg::held_t            held_reg;
    ssrp_pkg::held_t            held_next;
    logic [ssrp_pkg::IDX_W-1:0] off [ssrp_pkg::ITEM_COUNT];
    logic                       apply;
    logic                       cmd_err;

    function automatic logic [7:0] byte_at(input ssrp_pkg::window_t w,
                                           input logic [ssrp_pkg::IDX_W-1:0] i);
        logic [7:0] v;
        v = 8'h00;
        if (i < ssrp_pkg::IDX_W'(ssrp_pkg::WINDOW_BYTES))
            v = w[i];
        return v;
    endfunction

    function automatic logic [7:0] byte_plus(input ssrp_pkg::window_t w,
                                             input logic [ssrp_pkg::IDX_W-1:0] i,
                                             input int k);
        return byte_at(w, i + ssrp_pkg::IDX_W'(k));
    endfunction

    // Work out where each item starts
    always_comb
    begin
        for (int b = 0; b < ssrp_pkg::ITEM_COUNT; b++)
            off[b] = ssrp_pkg::item_offset(status_items, 3'(b));
    end

    assign apply   = ev.done && !ev.timeout && ev.sum_ok;
    assign cmd_err = window[0][ssrp_pkg::CMD_ERROR_BIT];

    // Pick the selected items out of the reply
    always_comb
    begin
        held_next = held_reg;
        if (apply)
        begin
            held_next.status = window[0];
            if (!cmd_err)
            begin
                if (status_items[ssrp_pkg::ITEM_POS])
                    held_next.position = {byte_plus(window, off[ssrp_pkg::ITEM_POS], 3),
                                          byte_plus(window, off[ssrp_pkg::ITEM_POS], 2),
                                          byte_plus(window, off[ssrp_pkg::ITEM_POS], 1),
                                          byte_plus(window, off[ssrp_pkg::ITEM_POS], 0)};
                if (status_items[ssrp_pkg::ITEM_AD])
                    held_next.adc = byte_plus(window, off[ssrp_pkg::ITEM_AD], 0);
                if (status_items[ssrp_pkg::ITEM_VEL])
                    held_next.velocity = {byte_plus(window, off[ssrp_pkg::ITEM_VEL], 1),
                                          byte_plus(window, off[ssrp_pkg::ITEM_VEL], 0)};
                if (status_items[ssrp_pkg::ITEM_AUX])
                    held_next.aux = byte_plus(window, off[ssrp_pkg::ITEM_AUX], 0);
                if (status_items[ssrp_pkg::ITEM_HOME])
                    held_next.home = {byte_plus(window, off[ssrp_pkg::ITEM_HOME], 3),
                                      byte_plus(window, off[ssrp_pkg::ITEM_HOME], 2),
                                      byte_plus(window, off[ssrp_pkg::ITEM_HOME], 1),
                                      byte_plus(window, off[ssrp_pkg::ITEM_HOME], 0)};
                if (status_items[ssrp_pkg::ITEM_ID])
                begin
                    held_next.mtype   = byte_plus(window, off[ssrp_pkg::ITEM_ID], 0);
                    held_next.version = byte_plus(window, off[ssrp_pkg::ITEM_ID], 1);
                end
                if (status_items[ssrp_pkg::ITEM_PERROR])
                    held_next.perror = {byte_plus(window, off[ssrp_pkg::ITEM_PERROR], 1),
                                        byte_plus(window, off[ssrp_pkg::ITEM_PERROR], 0)};
                if (status_items[ssrp_pkg::ITEM_POINTS])
                    held_next.points = byte_plus(window, off[ssrp_pkg::ITEM_POINTS], 0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else
            held_reg <= held_next;
    end

    assign held = held_reg;

endmodule

// ----- hdl/servo_status_reply_parser.sv -----
// Top level of the servo status reply parser.
`timescale 1ns / 1ps

// Takes a servo module's status reply one byte per request on the s_ side
// (tuser high marks a timeout that abandons a partial reply) and gives one
// result per finished or abandoned reply on the m_ side: an outcome code
// and every held status value. One request is taken every clock cycle as
// long as the result side keeps up; a byte passes through an input register
// and the parsing logic, and the result is registered as the request that
// ends the reply leaves the input register. The result waits in its own
// register while further bytes are taken; only the request that ends the
// next reply waits until the result is taken. The status_items register
// picks the items in the reply and so its length; write it between replies.
// The reply byte store needs no clearing after reset.
module servo_status_reply_parser #(
    parameter int REPLY_MAX_BYTES = ssrp_pkg::REPLY_MAX_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // request side
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic [0:0]   s_tuser,   // [0] timeout
    // result side
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] outcome, [9:2] status_byte, [41:10] position, [49:42] adc_value,
    // [65:50] velocity, [73:66] aux_status, [105:74] home_position,
    // [113:106] module_type, [121:114] module_version,
    // [137:122] position_error, [145:138] path_points, [151:146] zero
    output logic [151:0] m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                in_tmo_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          outcome_reg;
    logic [1:0]          outcome_next;
    logic [7:0]          status_items_reg;
    logic                advance;
    logic                s_accept;
    logic                ends_reply;
    ssrp_pkg::frame_ev_t ev;
    ssrp_pkg::window_t   window;
    ssrp_pkg::held_t     held;

    // Handshake control: only a request that ends a reply waits for the result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !ends_reply);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg && !m_tready;
        if (ev.done)
            out_valid_next = 1'b1;
    end

    // Classify the finished reply
    always_comb
    begin
        priority if (ev.timeout)
            outcome_next = ssrp_pkg::OUTCOME_SHORT;
        else if (!ev.sum_ok)
            outcome_next = ssrp_pkg::OUTCOME_BAD_SUM;
        else if (window[0][ssrp_pkg::CMD_ERROR_BIT])
            outcome_next = ssrp_pkg::OUTCOME_CMD_ERR;
        else
            outcome_next = ssrp_pkg::OUTCOME_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            status_items_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && (paddr[2] == ssrp_pkg::REG_STATUS_ITEMS))
                status_items_reg <= pwdata[7:0];
        end
    end

    // Hold the request and the outcome
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_tmo_reg  <= s_tuser[0];
        end
        if (ev.done)
            outcome_reg <= outcome_next;
    end

    ssrp_frame #(
        .DEPTH(REPLY_MAX_BYTES)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .timeout     (in_tmo_reg),
        .status_items(status_items_reg),
        .ends_reply  (ends_reply),
        .ev          (ev),
        .window      (window)
    );

    ssrp_fields u_fields (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev),
        .window      (window),
        .status_items(status_items_reg),
        .held        (held)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, held.points, held.perror, held.version, held.mtype,
                       held.home, held.aux, held.velocity, held.adc, held.position,
                       held.status, outcome_reg};

    // Register read back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ssrp_pkg::REG_STATUS_ITEMS) ?
                    {24'd0, status_items_reg} : 32'd0;

endmodule

// ----- hdl/ssrp_checker.sv -----
// Port-level checks of the servo status reply parser, bound to the top level.
`timescale 1ns / 1ps
`include "servo_status_reply_parser_defines.svh"

module ssrp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata
);

    // A waiting result holds still
    `SSRP_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Requests stall only behind a stalled result
    `SSRP_ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid && !m_tready, "request side stalled without result back-pressure")

    // An ok reply carries a status with the command error bit clear
    `SSRP_ASSERT_SAME(a_ok_status, m_tvalid && (m_tdata[1:0] == ssrp_pkg::OUTCOME_OK), !m_tdata[2], "ok outcome with command error bit set")

    // A command error reply carries a status with that bit set
    `SSRP_ASSERT_SAME(a_cmd_status, m_tvalid && (m_tdata[1:0] == ssrp_pkg::OUTCOME_CMD_ERR), m_tdata[2], "command error outcome with bit clear")

endmodule

bind servo_status_reply_parser ssrp_checker u_ssrp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the servo status reply parser.
`timescale 1ns / 1ps

module tb;

    // Held values as they travel in m_tdata, outcome in the lowest bits
    typedef struct {
        logic [1:0]  outcome;
        logic [7:0]  status;
        logic [31:0] position;   // signed
        logic [7:0]  adc;
        logic [15:0] velocity;   // signed
        logic [7:0]  aux;
        logic [31:0] home;
        logic [7:0]  mtype;
        logic [7:0]  version;
        logic [15:0] perror;     // signed
        logic [7:0]  points;
    } report_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_TIMEOUT,
        ROW_ITEMS
    } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] value;
        bit         pin;
        logic [1:0] outcome;
    } stim_row_t;

    localparam logic [2:0] ITEMS_ADDR = 3'(4 * ssrp_pkg::REG_STATUS_ITEMS);
    localparam int         LONG_HOLD_CYCLES = 400;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] rx_byte
    logic [0:0]   s_tuser;   // [0] timeout
    logic         m_tvalid;
    logic         m_tready;
    // [1:0] outcome, [9:2] status, [41:10] position, [49:42] adc,
    // [65:50] velocity, [73:66] aux, [105:74] home, [113:106] type,
    // [121:114] version, [137:122] position error, [145:138] path points
    logic [151:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow of the parser state
    logic [7:0]   cfg_items;
    logic [4:0]   rx_index;
    logic [7:0]   rx_sum;
    logic [7:0]   rx_bytes [ssrp_pkg::WINDOW_BYTES];
    report_t      held_now;
    report_t      reply_q [$];

    // Run control and bookkeeping
    bit           idle_on;
    bit           hold_request;
    int unsigned  mismatch_count;
    int unsigned  request_count;
    int unsigned  result_count;
    int unsigned  timeout_count;
    int unsigned  settings_count;

    // Fixed-content replies; outcome typed in only where it is obvious
    stim_row_t directed_rows [26] = '{
        '{ROW_TIMEOUT, 8'h5A, 1'b1, ssrp_pkg::OUTCOME_SHORT},
        '{ROW_BYTE,    8'h00, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h00, 1'b1, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h01, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h02, 1'b1, ssrp_pkg::OUTCOME_BAD_SUM},
        '{ROW_BYTE,    8'hFF, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'hFF, 1'b1, ssrp_pkg::OUTCOME_CMD_ERR},
        '{ROW_ITEMS,   8'hFF, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h00, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h80, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h7F, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_TIMEOUT, 8'hA5, 1'b1, ssrp_pkg::OUTCOME_SHORT},
        '{ROW_BYTE,    8'h00, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h10, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h20, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h30, 1'b0, ssrp_pkg::OUTCOME_OK},
        // grow-then-shrink: reply keeps going under the shorter mask
        '{ROW_ITEMS,   8'h03, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h40, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h50, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'hF0, 1'b1, ssrp_pkg::OUTCOME_OK},
        '{ROW_ITEMS,   8'hFF, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h04, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h05, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h06, 1'b0, ssrp_pkg::OUTCOME_OK},
        // mask shrinks below the bytes already taken: next byte is the checksum
        '{ROW_ITEMS,   8'h00, 1'b0, ssrp_pkg::OUTCOME_OK},
        '{ROW_BYTE,    8'h0F, 1'b1, ssrp_pkg::OUTCOME_OK}
    };

    servo_status_reply_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Reply length for an item mask, status and checksum bytes included
    function automatic int unsigned frame_length(input logic [7:0] m);
        int unsigned sizes [8] = '{4, 1, 2, 1, 4, 2, 2, 1};
        int unsigned n;
        n = 2;
        for (int b = 0; b < 8; b++)
        begin
            if (m[b])
                n += sizes[b];
        end
        return n;
    endfunction

    // Little-endian value from the captured reply bytes
    function automatic logic [31:0] stored_le(input int unsigned at, input int unsigned count);
        logic [31:0] v;
        v = '0;
        for (int unsigned k = 0; k < count; k++)
        begin
            if (at + k < ssrp_pkg::WINDOW_BYTES)
                v |= 32'(rx_bytes[at + k]) << (8 * k);
        end
        return v;
    endfunction

    // Advance the shadow parser by one request, queue the result it causes
    task automatic track_request(input logic [7:0] b, input logic tmo);
        int unsigned last;
        int unsigned p;
        report_t     r;
        last = frame_length(cfg_items) - 1;
        if (tmo)
        begin
            rx_index = '0;
            rx_sum = '0;
            r = held_now;
            r.outcome = ssrp_pkg::OUTCOME_SHORT;
            reply_q.push_back(r);
        end
        else if (rx_index < last)
        begin
            if (rx_index < ssrp_pkg::WINDOW_BYTES)
                rx_bytes[rx_index] = b;
            rx_sum = rx_sum + b;
            rx_index = rx_index + 5'd1;
        end
        else
        begin
            if (rx_sum != b)
                held_now.outcome = ssrp_pkg::OUTCOME_BAD_SUM;
            else
            begin
                held_now.status = rx_bytes[0];
                if (held_now.status[ssrp_pkg::CMD_ERROR_BIT])
                    held_now.outcome = ssrp_pkg::OUTCOME_CMD_ERR;
                else
                begin
                    // walk the selected items in mask bit order
                    p = 1;
                    if (cfg_items[ssrp_pkg::ITEM_POS])
                    begin
                        held_now.position = stored_le(p, 4);
                        p += 4;
                    end
                    if (cfg_items[ssrp_pkg::ITEM_AD])
                    begin
                        held_now.adc = 8'(stored_le(p, 1));
                        p += 1;
                    end
                    if (cfg_items[ssrp_pkg::ITEM_VEL])
                    begin
                        held_now.velocity = 16'(stored_le(p, 2));
                        p += 2;
                    end
                    if (cfg_items[ssrp_pkg::ITEM_AUX])
                    begin
                        held_now.aux = 8'(stored_le(p, 1));
                        p += 1;
                    end
                    if (cfg_items[ssrp_pkg::ITEM_HOME])
                    begin
                        held_now.home = stored_le(p, 4);
                        p += 4;
                    end
                    if (cfg_items[ssrp_pkg::ITEM_ID])
                    begin
                        held_now.mtype = 8'(stored_le(p, 1));
                        held_now.version = 8'(stored_le(p + 1, 1));
                        p += 2;
                    end
                    if (cfg_items[ssrp_pkg::ITEM_PERROR])
                    begin
                        held_now.perror = 16'(stored_le(p, 2));
                        p += 2;
                    end
                    if (cfg_items[ssrp_pkg::ITEM_POINTS])
                        held_now.points = 8'(stored_le(p, 1));
                    held_now.outcome = ssrp_pkg::OUTCOME_OK;
                end
            end
            rx_index = '0;
            rx_sum = '0;
            reply_q.push_back(held_now);
        end
    endtask

    // Offer one request, with an optional gap first; returns at a falling edge
    task automatic push_request(input logic [7:0] b, input logic tmo);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tuser = tmo;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_request(b, tmo);
        request_count++;
        if (tmo)
            timeout_count++;
        @(negedge clk);
    endtask

    // Wait for the parser to go quiet, then write and read back the item mask
    task automatic write_items(input logic [7:0] m);
        logic [31:0] readback;
        s_tvalid = 1'b0;
        while (reply_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ITEMS_ADDR;
        pwdata = {24'($urandom), m};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        cfg_items = m;
        settings_count++;
        if (readback[7:0] !== m)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("status_items readback expected %h got %h", m, readback[7:0]);
        end
    endtask

    // Random byte leaning toward the extremes
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 3)];
        return 8'($urandom);
    endfunction

    // Send one reply for the current mask: well-formed, cut short or broken
    task automatic send_reply();
        int unsigned len;
        int unsigned roll;
        int unsigned cut;
        logic [7:0]  b;
        logic [7:0]  sum;
        len = frame_length(cfg_items);
        roll = $urandom_range(0, 99);
        sum = '0;
        if (roll < 6)
            push_request(pick_byte(), 1'b1);
        else if (roll < 14)
        begin
            cut = $urandom_range(1, len - 1);
            for (int unsigned i = 0; i < cut; i++)
                push_request(pick_byte(), 1'b0);
            push_request(pick_byte(), 1'b1);
        end
        else
        begin
            b = pick_byte();
            b[ssrp_pkg::CMD_ERROR_BIT] = ($urandom_range(0, 99) < 15);
            for (int unsigned i = 0; i + 1 < len; i++)
            begin
                if (i != 0)
                    b = pick_byte();
                sum = sum + b;
                push_request(b, 1'b0);
            end
            if ($urandom_range(0, 99) < 20)
                sum = sum ^ 8'($urandom_range(1, 255));
            push_request(sum, 1'b0);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready = 1'b0;
                for (int i = 0; i < LONG_HOLD_CYCLES; i++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d: %s expected %h got %h", result_count, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        report_t want;
        report_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.outcome  = m_tdata[1:0];
            got.status   = m_tdata[9:2];
            got.position = m_tdata[41:10];
            got.adc      = m_tdata[49:42];
            got.velocity = m_tdata[65:50];
            got.aux      = m_tdata[73:66];
            got.home     = m_tdata[105:74];
            got.mtype    = m_tdata[113:106];
            got.version  = m_tdata[121:114];
            got.perror   = m_tdata[137:122];
            got.points   = m_tdata[145:138];
            if (reply_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing expected", result_count);
            end
            else
            begin
                want = reply_q.pop_front();
                check_field("outcome", 32'(want.outcome), 32'(got.outcome));
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("position", want.position, got.position);
                check_field("adc", 32'(want.adc), 32'(got.adc));
                check_field("velocity", 32'(want.velocity), 32'(got.velocity));
                check_field("aux", 32'(want.aux), 32'(got.aux));
                check_field("home", want.home, got.home);
                check_field("module_type", 32'(want.mtype), 32'(got.mtype));
                check_field("module_version", 32'(want.version), 32'(got.version));
                check_field("position_error", 32'(want.perror), 32'(got.perror));
                check_field("path_points", 32'(want.points), 32'(got.points));
            end
            result_count++;
        end
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        int          phase;
        int unsigned drain;
        logic [7:0]  m;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_request = 1'b0;
        idle_on = 1'b1;
        cfg_items = '0;
        rx_index = '0;
        rx_sum = '0;
        held_now = '{default: '0};
        mismatch_count = 0;
        request_count = 0;
        result_count = 0;
        timeout_count = 0;
        settings_count = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed replies
        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_ITEMS:   write_items(directed_rows[i].value);
                ROW_TIMEOUT: push_request(directed_rows[i].value, 1'b1);
                default:     push_request(directed_rows[i].value, 1'b0);
            endcase
            if (directed_rows[i].pin)
                reply_q[$].outcome = directed_rows[i].outcome;
        end

        // Random phases, each under its own item mask
        phase = 0;
        while (request_count < 900)
        begin
            case (phase % 5)
                0:       m = 8'hFF;
                1:       m = 8'h00;
                default: m = 8'($urandom);
            endcase
            write_items(m);
            idle_on = (request_count < 780) && ($urandom_range(0, 3) != 0);
            if (phase == 3)
                hold_request = 1'b1;
            repeat ($urandom_range(3, 10)) send_reply();
            // leave a reply open now and then so the next mask lands mid-reply
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, frame_length(cfg_items) - 1))
                    push_request(pick_byte(), 1'b0);
            phase++;
        end
        s_tvalid = 1'b0;
        idle_on = 1'b0;

        // Drain what is still expected, then allow for trailing results
        drain = 0;
        while (reply_q.size() != 0 && drain < 5000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (10) @(negedge clk);
        if (reply_q.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected results never arrived", reply_q.size());
        end

        $display("run: %0d requests (%0d timeouts), %0d results checked, %0d mask settings",
                 request_count, timeout_count, result_count, settings_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ssrp_pkg.sv
hdl/ssrp_frame.sv
hdl/ssrp_fields.sv
hdl/servo_status_reply_parser.sv
hdl/ssrp_checker.sv
tb/tb.sv
